// File: design/masked_serpentine_pixel_mapper_defines.svh
// Assertion macros shared by the pixel mapper RTL.
// They expect clk_i and rst_ni in the scope where they are used.
`ifndef MASKED_SERPENTINE_PIXEL_MAPPER_DEFINES_SVH
`define MASKED_SERPENTINE_PIXEL_MAPPER_DEFINES_SVH

`ifndef SYNTHESIS
`define MSP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("msp assertion failed");
`define MSP_ASSERT_NEVER(lbl, cond) \
  `MSP_ASSERT(lbl, !(cond))
`else
`define MSP_ASSERT(lbl, prop)
`define MSP_ASSERT_NEVER(lbl, cond)
`endif

`endif

// File: design/msp_pkg.sv
package msp_pkg;

  localparam int unsigned IDX_W     = 11;
  localparam int unsigned RGB_W     = 24;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned GAIN_W    = 9;
  localparam int unsigned OFF_W     = 11;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned MASK_DEPTH = 128;
  localparam int unsigned MASK_AW   = 7;
  localparam int unsigned APB_AW    = 4;
  localparam int unsigned APB_DW    = 32;

  localparam logic [GAIN_W-1:0] GAIN_FULL = 9'd256;
  localparam logic [2:0]        MSB_BIT   = 3'd7;

  typedef enum logic [1:0] {
    PANEL_FL = 2'd0,
    PANEL_FR = 2'd1,
    PANEL_SL = 2'd2,
    PANEL_SR = 2'd3
  } panel_e;

  typedef enum logic [1:0] {
    WM_UNCOND   = 2'd0,
    WM_MASKED   = 2'd1,
    WM_CHECKER  = 2'd2,
    WM_RESERVED = 2'd3
  } write_mode_e;

  typedef enum logic {
    REQ_PIXEL     = 1'b0,
    REQ_MASK_LOAD = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    REG_OFF_FL = 2'd0,
    REG_OFF_FR = 2'd1,
    REG_OFF_SL = 2'd2,
    REG_OFF_SR = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic             in_range;
    logic [IDX_W-1:0] base;
    logic [IDX_W-1:0] minor;
  } msp_map_t;

endpackage

// File: design/masked_serpentine_pixel_mapper.sv
// Pixel mapper for four LED panels. A pixel request is turned into a strand
// pixel index, a brightness-scaled color and a write enable; a mask byte load
// writes one byte of the 128-byte mask RAM and produces no output transfer.
// The block takes one request per clock unless a stalled output holds it; the
// input stage reads the mask RAM, the second stage maps the coordinate and
// scales the color, and the third adds the panel offset, each registering its
// result. The single mask RAM port handles one load or one read per
// cycle, which is one per accepted item. A stalled output holds the pipeline
// without losing or repeating anything. Mask contents are undefined until
// loaded. Offsets are set through the APB port at byte addresses 0, 4, 8, 12.
`include "masked_serpentine_pixel_mapper_defines.svh"

module masked_serpentine_pixel_mapper #(
  parameter int unsigned FL_COLS     = 16,
  parameter int unsigned FL_ROWS     = 16,
  parameter int unsigned FR_ROWS     = 16,
  parameter int unsigned FR_PHYS_RUN = 8,
  parameter int unsigned SIDE_COLS   = 32,
  parameter int unsigned SIDE_ROWS   = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // APB configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [msp_pkg::APB_AW-1:0]  paddr,
  input  logic [msp_pkg::APB_DW-1:0]  pwdata,
  output logic [msp_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  // Request channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        req_type_i,
  input  logic [1:0]                  panel_sel_i,
  input  logic [4:0]                  coord_x_i,
  input  logic [3:0]                  coord_y_i,
  input  logic [msp_pkg::RGB_W-1:0]   rgb_in_i,
  input  logic [1:0]                  write_mode_i,
  input  logic [msp_pkg::GAIN_W-1:0]  gain_i,
  input  logic [4:0]                  mask_byte_addr_i,
  input  logic [7:0]                  mask_byte_val_i,
  // Result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [msp_pkg::IDX_W-1:0]   pixel_index_o,
  output logic [msp_pkg::RGB_W-1:0]   rgb_out_o,
  output logic                        write_enable_o
);
  import msp_pkg::*;

  localparam logic [8:0] FL_BW = 9'(FL_COLS);
  localparam logic [8:0] FR_BW = 9'(FR_PHYS_RUN);
  localparam logic [8:0] SD_BW = 9'(SIDE_COLS);

  // Configuration registers
  logic [OFF_W-1:0] off_fl_q, off_fr_q, off_sl_q, off_sr_q;
  logic             apb_wr;
  reg_idx_e         reg_idx;

  // Pipeline control
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic en2, en3, s2_free, s3_free;
  logic accept, is_pixel;

  // Input stage
  panel_e           in_panel;
  logic [8:0]       row_w;
  logic [8:0]       bit_idx;
  logic             ram_we, ram_re;
  logic [MASK_AW-1:0] ram_addr;
  logic [BYTE_W-1:0]  ram_rdata;

  // Stage 1
  panel_e           s1_panel_q;
  logic [4:0]       s1_x_q;
  logic [3:0]       s1_y_q;
  logic [RGB_W-1:0] s1_rgb_q;
  write_mode_e      s1_mode_q;
  logic [GAIN_W-1:0] s1_gain_q;
  logic [2:0]       s1_bit_q;
  msp_map_t         s1_map;
  logic [RGB_W-1:0] s1_scaled;
  logic             mask_bit;
  logic             s1_we;

  // Stage 2
  panel_e           s2_panel_q;
  logic             s2_we_q;
  logic [IDX_W-1:0] s2_base_q, s2_minor_q;
  logic [RGB_W-1:0] s2_rgb_q;
  logic [OFF_W-1:0] s2_offset;
  logic [IDX_W-1:0] s2_index;

  // Stage 3 (output register)
  logic [IDX_W-1:0] s3_index_q;
  logic [RGB_W-1:0] s3_rgb_q;
  logic             s3_we_q;

  // ---------------- Configuration ----------------
  assign apb_wr = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_fl_q <= 11'd0;
      off_fr_q <= 11'd256;
      off_sl_q <= 11'd512;
      off_sr_q <= 11'd768;
    end else if (apb_wr) begin
      unique case (reg_idx)
        REG_OFF_FL: off_fl_q <= pwdata[OFF_W-1:0];
        REG_OFF_FR: off_fr_q <= pwdata[OFF_W-1:0];
        REG_OFF_SL: off_sl_q <= pwdata[OFF_W-1:0];
        REG_OFF_SR: off_sr_q <= pwdata[OFF_W-1:0];
        default:    off_fl_q <= off_fl_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_OFF_FL: prdata = APB_DW'(off_fl_q);
      REG_OFF_FR: prdata = APB_DW'(off_fr_q);
      REG_OFF_SL: prdata = APB_DW'(off_sl_q);
      REG_OFF_SR: prdata = APB_DW'(off_sr_q);
      default:    prdata = '0;
    endcase
  end

  // ---------------- Pipeline control ----------------
  assign s3_free    = !s3_valid_q || out_ready_i;
  assign en3        = s2_valid_q && s3_free;
  assign s2_free    = !s2_valid_q || en3;
  assign en2        = s1_valid_q && s2_free;
  assign in_ready_o = !s1_valid_q || en2;
  assign accept     = in_valid_i && in_ready_o;
  assign is_pixel   = (req_type_e'(req_type_i) == REQ_PIXEL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      // Mask loads finish at the input transfer and leave a bubble behind.
      if (accept) begin
        s1_valid_q <= is_pixel;
      end else if (en2) begin
        s1_valid_q <= 1'b0;
      end
      if (en2) begin
        s2_valid_q <= 1'b1;
      end else if (en3) begin
        s2_valid_q <= 1'b0;
      end
      if (en3) begin
        s3_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        s3_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- Input stage: mask RAM access ----------------
  assign in_panel = panel_e'(panel_sel_i);

  always_comb begin
    unique case (in_panel)
      PANEL_FL: row_w = FL_BW;
      PANEL_FR: row_w = FR_BW;
      PANEL_SL: row_w = SD_BW;
      PANEL_SR: row_w = SD_BW;
      default:  row_w = FL_BW;
    endcase
  end

  // Bit index y*width+x; its byte part wraps within the panel's 32 bytes.
  assign bit_idx = 9'(9'(coord_y_i) * row_w) + 9'(coord_x_i);
  assign ram_we  = accept && !is_pixel;
  assign ram_re  = accept && is_pixel;
  assign ram_addr = ram_we ? {panel_sel_i, mask_byte_addr_i}
                           : {panel_sel_i, bit_idx[7:3]};

  msp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MASK_DEPTH)
  ) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (mask_byte_val_i),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      s1_panel_q <= in_panel;
      s1_x_q     <= coord_x_i;
      s1_y_q     <= coord_y_i;
      s1_rgb_q   <= rgb_in_i;
      s1_mode_q  <= write_mode_e'(write_mode_i);
      s1_gain_q  <= gain_i;
      s1_bit_q   <= bit_idx[2:0];
    end
  end

  // ---------------- Stage 1: map, mask decision, color scale ----------------
  msp_xy_map #(
    .FL_COLS     (FL_COLS),
    .FL_ROWS     (FL_ROWS),
    .FR_ROWS     (FR_ROWS),
    .FR_PHYS_RUN (FR_PHYS_RUN),
    .SIDE_COLS   (SIDE_COLS),
    .SIDE_ROWS   (SIDE_ROWS)
  ) u_xy_map (
    .panel_i (s1_panel_q),
    .x_i     (s1_x_q),
    .y_i     (s1_y_q),
    .map_o   (s1_map)
  );

  msp_color_scale u_color_scale (
    .rgb_i  (s1_rgb_q),
    .gain_i (s1_gain_q),
    .rgb_o  (s1_scaled)
  );

  // Mask bytes are read MSB first.
  assign mask_bit = ram_rdata[MSB_BIT - s1_bit_q];

  always_comb begin
    unique case (s1_mode_q)
      WM_UNCOND:   s1_we = 1'b1;
      WM_MASKED:   s1_we = mask_bit;
      WM_CHECKER:  s1_we = mask_bit && !(s1_x_q[0] ^ s1_y_q[0]);
      WM_RESERVED: s1_we = 1'b0;
      default:     s1_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_panel_q <= s1_panel_q;
      s2_we_q    <= s1_we && s1_map.in_range;
      s2_base_q  <= s1_map.base;
      s2_minor_q <= s1_map.minor;
      s2_rgb_q   <= s1_scaled;
    end
  end

  // ---------------- Stage 2: add panel offset ----------------
  always_comb begin
    unique case (s2_panel_q)
      PANEL_FL: s2_offset = off_fl_q;
      PANEL_FR: s2_offset = off_fr_q;
      PANEL_SL: s2_offset = off_sl_q;
      PANEL_SR: s2_offset = off_sr_q;
      default:  s2_offset = off_fl_q;
    endcase
  end

  // The index wraps modulo the strand length of 2048 pixels.
  assign s2_index = s2_offset + s2_base_q + s2_minor_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_we_q    <= s2_we_q;
      s3_index_q <= s2_we_q ? s2_index : '0;
      s3_rgb_q   <= s2_we_q ? s2_rgb_q : '0;
    end
  end

  assign out_valid_o    = s3_valid_q;
  assign pixel_index_o  = s3_index_q;
  assign rgb_out_o      = s3_rgb_q;
  assign write_enable_o = s3_we_q;

  // ---------------- Assertions ----------------
  `MSP_ASSERT_NEVER(a_ram_one_access, ram_we && ram_re)
  `MSP_ASSERT(a_disabled_zero,
    out_valid_o && !write_enable_o |-> pixel_index_o == '0 && rgb_out_o == '0)
  `MSP_ASSERT(a_reserved_no_write,
    en2 && s1_mode_q == WM_RESERVED |=> !s2_we_q)
  `MSP_ASSERT(a_stage2_holds,
    s2_valid_q && !en3 |=> s2_valid_q && $stable(s2_index))

endmodule

// File: design/msp_ram.sv
module msp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/msp_xy_map.sv
module msp_xy_map #(
  parameter int unsigned FL_COLS     = 16,
  parameter int unsigned FL_ROWS     = 16,
  parameter int unsigned FR_ROWS     = 16,
  parameter int unsigned FR_PHYS_RUN = 8,
  parameter int unsigned SIDE_COLS   = 32,
  parameter int unsigned SIDE_ROWS   = 8
) (
  input  msp_pkg::panel_e  panel_i,
  input  logic [4:0]       x_i,
  input  logic [3:0]       y_i,
  output msp_pkg::msp_map_t map_o
);
  import msp_pkg::*;

  localparam logic [IDX_W-1:0] FL_L  = IDX_W'(FL_ROWS);
  localparam logic [IDX_W-1:0] FR_L  = IDX_W'(FR_PHYS_RUN);
  localparam logic [IDX_W-1:0] SD_L  = IDX_W'(SIDE_ROWS);
  localparam logic [IDX_W-1:0] SD_MX = IDX_W'(SIDE_COLS - 1);
  localparam logic [5:0]       FL_W  = 6'(FL_COLS);
  localparam logic [5:0]       FR_W  = 6'(FR_PHYS_RUN);
  localparam logic [5:0]       SD_W  = 6'(SIDE_COLS);
  localparam logic [4:0]       FL_H  = 5'(FL_ROWS);
  localparam logic [4:0]       FR_H  = 5'(FR_ROWS);
  localparam logic [4:0]       SD_H  = 5'(SIDE_ROWS);

  logic [IDX_W-1:0] x_ext, y_ext;
  logic [IDX_W-1:0] major, minor_n, run;
  logic [5:0]       wid;
  logic [4:0]       hgt;

  assign x_ext = IDX_W'(x_i);
  assign y_ext = IDX_W'(y_i);

  // Every layout is a serpentine along a major axis with runs of length run;
  // the panels differ in which axis is major and which axes are mirrored.
  always_comb begin
    unique case (panel_i)
      PANEL_FL: begin
        major   = x_ext;
        minor_n = y_ext;
        run     = FL_L;
        wid     = FL_W;
        hgt     = FL_H;
      end
      PANEL_FR: begin
        major   = y_ext;
        minor_n = x_ext;
        run     = FR_L;
        wid     = FR_W;
        hgt     = FR_H;
      end
      PANEL_SL: begin
        major   = x_ext;
        minor_n = SD_L - IDX_W'(1) - y_ext;
        run     = SD_L;
        wid     = SD_W;
        hgt     = SD_H;
      end
      PANEL_SR: begin
        major   = SD_MX - x_ext;
        minor_n = SD_L - IDX_W'(1) - y_ext;
        run     = SD_L;
        wid     = SD_W;
        hgt     = SD_H;
      end
      default: begin
        major   = x_ext;
        minor_n = y_ext;
        run     = FL_L;
        wid     = FL_W;
        hgt     = FL_H;
      end
    endcase
  end

  assign map_o.in_range = ({1'b0, x_i} < wid) && ({1'b0, y_i} < hgt);
  assign map_o.base     = major * run;
  assign map_o.minor    = major[0] ? (run - IDX_W'(1) - minor_n) : minor_n;

endmodule

// File: design/msp_color_scale.sv
module msp_color_scale (
  input  logic [msp_pkg::RGB_W-1:0]  rgb_i,
  input  logic [msp_pkg::GAIN_W-1:0] gain_i,
  output logic [msp_pkg::RGB_W-1:0]  rgb_o
);
  import msp_pkg::*;

  logic [GAIN_W-1:0] gain_sat;
  logic [15:0]       prod_r, prod_g, prod_b;

  assign gain_sat = (gain_i > GAIN_FULL) ? GAIN_FULL : gain_i;

  // 255 * 256 still fits in 16 bits, so the top byte is the truncated result.
  assign prod_r = 16'(rgb_i[23:16] * gain_sat);
  assign prod_g = 16'(rgb_i[15:8] * gain_sat);
  assign prod_b = 16'(rgb_i[7:0] * gain_sat);

  assign rgb_o = {prod_r[15:8], prod_g[15:8], prod_b[15:8]};

endmodule

// File: verif/pixel_result_checker.sv
module pixel_result_checker
  import msp_pkg::*;
#(
  parameter int unsigned FL_COLS     = 16,
  parameter int unsigned FL_ROWS     = 16,
  parameter int unsigned FR_ROWS     = 16,
  parameter int unsigned FR_PHYS_RUN = 8,
  parameter int unsigned SIDE_COLS   = 32,
  parameter int unsigned SIDE_ROWS   = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [APB_AW-1:0]   paddr_i,
  input  logic [APB_DW-1:0]   pwdata_i,
  input  logic [APB_DW-1:0]   prdata_i,
  input  logic                pready_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                req_type_i,
  input  logic [1:0]          panel_sel_i,
  input  logic [4:0]          coord_x_i,
  input  logic [3:0]          coord_y_i,
  input  logic [RGB_W-1:0]    rgb_in_i,
  input  logic [1:0]          write_mode_i,
  input  logic [GAIN_W-1:0]   gain_i,
  input  logic [4:0]          mask_byte_addr_i,
  input  logic [7:0]          mask_byte_val_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [IDX_W-1:0]    pixel_index_i,
  input  logic [RGB_W-1:0]    rgb_out_i,
  input  logic                write_enable_i,
  output int unsigned         pending_o,
  output int unsigned         errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [RGB_W-1:0] rgb;
    logic             we;
  } pixel_result_t;

  logic [OFF_W-1:0]  offsets [4];
  logic [BYTE_W-1:0] mask_copy [MASK_DEPTH];
  pixel_result_t     expected_pixels [$];
  int unsigned       mismatches = 0;

  initial pending_o = 0;
  assign errors_o = mismatches;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    // Keep the log readable when something breaks badly.
    if (mismatches <= 40)
      $display("%0t checker: %s mismatch, got %0h, expected %0h", $realtime, what, got, want);
  endtask

  function automatic pixel_result_t predict_pixel(panel_e p, logic [4:0] x, logic [3:0] y,
                                                  logic [RGB_W-1:0] rgb, write_mode_e mode,
                                                  logic [GAIN_W-1:0] gain);
    pixel_result_t   res;
    int unsigned     w, h, bitn, mx, my, pos;
    logic [GAIN_W-1:0] g;
    logic            mbit;
    logic            en;
    res = '0;
    w = (p == PANEL_FL) ? FL_COLS : (p == PANEL_FR) ? FR_PHYS_RUN : SIDE_COLS;
    h = (p == PANEL_FL) ? FL_ROWS : (p == PANEL_FR) ? FR_ROWS : SIDE_ROWS;
    bitn = y * w + x;
    // Bit 0 of a panel mask is the MSB of its first byte.
    mbit = mask_copy[int'(p) * 32 + ((bitn >> 3) & 31)][7 - (bitn % 8)];
    if (x >= w || y >= h) en = 1'b0;
    else begin
      case (mode)
        WM_UNCOND:  en = 1'b1;
        WM_MASKED:  en = mbit;
        WM_CHECKER: en = mbit && ((x + y) % 2 == 0);
        default:    en = 1'b0;
      endcase
    end
    if (!en) return res;

    g = (gain > GAIN_FULL) ? GAIN_FULL : gain;
    for (int k = 0; k < 3; k++)
      res.rgb[8*k +: 8] = 8'((int'(rgb[8*k +: 8]) * int'(g)) >> 8);

    if (p == PANEL_FR) begin
      pos = y * FR_PHYS_RUN + ((y % 2 == 0) ? x : FR_PHYS_RUN - 1 - x);
    end else begin
      mx = x;
      my = y;
      if (p == PANEL_SL) begin
        my = h - 1 - y;
      end else if (p == PANEL_SR) begin
        mx = SIDE_COLS - 1 - x;
        my = h - 1 - y;
      end
      pos = mx * h + ((mx % 2 == 0) ? my : h - 1 - my);
    end
    res.index = IDX_W'(offsets[p] + pos);
    res.we = 1'b1;
    return res;
  endfunction

  always @(posedge clk_i) begin : watch
    pixel_result_t want;
    if (!rst_ni) begin
      expected_pixels.delete();
      offsets[REG_OFF_FL] = 11'd0;
      offsets[REG_OFF_FR] = 11'd256;
      offsets[REG_OFF_SL] = 11'd512;
      offsets[REG_OFF_SR] = 11'd768;
    end else begin
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) offsets[paddr_i[APB_AW-1:2]] = pwdata_i[OFF_W-1:0];
        else if (prdata_i !== APB_DW'(offsets[paddr_i[APB_AW-1:2]]))
          report_mismatch("register read", prdata_i, APB_DW'(offsets[paddr_i[APB_AW-1:2]]));
      end
      if (in_valid_i && in_ready_i) begin
        if (req_type_i == REQ_MASK_LOAD)
          mask_copy[{panel_sel_i, mask_byte_addr_i}] = mask_byte_val_i;
        else
          expected_pixels.push_back(predict_pixel(panel_e'(panel_sel_i), coord_x_i, coord_y_i,
                                                  rgb_in_i, write_mode_e'(write_mode_i),
                                                  gain_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected result transfer", 32'(pixel_index_i), 32'd0);
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_index_i !== want.index)
            report_mismatch("pixel_index", 32'(pixel_index_i), 32'(want.index));
          if (rgb_out_i !== want.rgb)
            report_mismatch("rgb_out", 32'(rgb_out_i), 32'(want.rgb));
          if (write_enable_i !== want.we)
            report_mismatch("write_enable", 32'(write_enable_i), 32'(want.we));
        end
      end
    end
    pending_o <= expected_pixels.size();
  end

endmodule

// File: verif/tb_top.sv
module tb_top;
  import msp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FL_COLS     = 16;
  localparam int unsigned FL_ROWS     = 16;
  localparam int unsigned FR_ROWS     = 16;
  localparam int unsigned FR_PHYS_RUN = 8;
  localparam int unsigned SIDE_COLS   = 32;
  localparam int unsigned SIDE_ROWS   = 8;

  typedef struct {
    req_type_e        kind;
    panel_e           panel;
    logic [4:0]       x;
    logic [3:0]       y;
    logic [RGB_W-1:0] rgb;
    write_mode_e      mode;
    logic [GAIN_W-1:0] gain;
    logic [4:0]       maddr;
    logic [7:0]       mval;
  } pixel_req_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              req_type_i = 1'b0;
  logic [1:0]        panel_sel_i = '0;
  logic [4:0]        coord_x_i = '0;
  logic [3:0]        coord_y_i = '0;
  logic [RGB_W-1:0]  rgb_in_i = '0;
  logic [1:0]        write_mode_i = '0;
  logic [GAIN_W-1:0] gain_i = '0;
  logic [4:0]        mask_byte_addr_i = '0;
  logic [7:0]        mask_byte_val_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [IDX_W-1:0]  pixel_index_o;
  logic [RGB_W-1:0]  rgb_out_o;
  logic              write_enable_o;

  int unsigned       pending;
  int unsigned       errors;
  logic [MASK_DEPTH-1:0] mask_loaded = '0;
  bit                calm = 1'b0;
  bit                sink_hold_req = 1'b0;

  always #5 clk_i = ~clk_i;

  masked_serpentine_pixel_mapper #(
    .FL_COLS(FL_COLS), .FL_ROWS(FL_ROWS), .FR_ROWS(FR_ROWS),
    .FR_PHYS_RUN(FR_PHYS_RUN), .SIDE_COLS(SIDE_COLS), .SIDE_ROWS(SIDE_ROWS)
  ) uut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .req_type_i, .panel_sel_i, .coord_x_i, .coord_y_i,
    .rgb_in_i, .write_mode_i, .gain_i, .mask_byte_addr_i, .mask_byte_val_i,
    .out_valid_o, .out_ready_i, .pixel_index_o, .rgb_out_o, .write_enable_o
  );

  pixel_result_checker #(
    .FL_COLS(FL_COLS), .FL_ROWS(FL_ROWS), .FR_ROWS(FR_ROWS),
    .FR_PHYS_RUN(FR_PHYS_RUN), .SIDE_COLS(SIDE_COLS), .SIDE_ROWS(SIDE_ROWS)
  ) checker_i (
    .clk_i, .rst_ni,
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .prdata_i(prdata), .pready_i(pready),
    .in_valid_i, .in_ready_i(in_ready_o), .req_type_i, .panel_sel_i, .coord_x_i,
    .coord_y_i, .rgb_in_i, .write_mode_i, .gain_i, .mask_byte_addr_i, .mask_byte_val_i,
    .out_valid_i(out_valid_o), .out_ready_i, .pixel_index_i(pixel_index_o),
    .rgb_out_i(rgb_out_o), .write_enable_i(write_enable_o),
    .pending_o(pending), .errors_o(errors)
  );

  function automatic int unsigned panel_cols(panel_e p);
    return (p == PANEL_FL) ? FL_COLS : (p == PANEL_FR) ? FR_PHYS_RUN : SIDE_COLS;
  endfunction

  function automatic int unsigned panel_rows(panel_e p);
    return (p == PANEL_FL) ? FL_ROWS : (p == PANEL_FR) ? FR_ROWS : SIDE_ROWS;
  endfunction

  // Fields that a request kind ignores still get random values.
  function automatic pixel_req_t pix(panel_e p, int unsigned x, int unsigned y,
                                     write_mode_e mode, logic [RGB_W-1:0] rgb,
                                     int unsigned gain);
    pixel_req_t r;
    r.kind = REQ_PIXEL;
    r.panel = p;
    r.x = 5'(x);
    r.y = 4'(y);
    r.rgb = rgb;
    r.mode = mode;
    r.gain = GAIN_W'(gain);
    r.maddr = 5'($urandom);
    r.mval = 8'($urandom);
    return r;
  endfunction

  function automatic pixel_req_t mload(panel_e p, logic [4:0] addr, logic [7:0] val);
    pixel_req_t r;
    r = pix(p, $urandom_range(0, 31), $urandom_range(0, 15),
            write_mode_e'($urandom_range(0, 3)), RGB_W'($urandom), $urandom_range(0, 511));
    r.kind = REQ_MASK_LOAD;
    r.maddr = addr;
    r.mval = val;
    return r;
  endfunction

  task automatic send_item(input pixel_req_t r);
    in_valid_i <= 1'b1;
    req_type_i <= r.kind;
    panel_sel_i <= r.panel;
    coord_x_i <= r.x;
    coord_y_i <= r.y;
    rgb_in_i <= r.rgb;
    write_mode_i <= r.mode;
    gain_i <= r.gain;
    mask_byte_addr_i <= r.maddr;
    mask_byte_val_i <= r.mval;
    do @(posedge clk_i); while (!in_ready_o);
    if (r.kind == REQ_MASK_LOAD) mask_loaded[{r.panel, r.maddr}] = 1'b1;
    if (!calm && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Masked requests only go out once the mask byte they read has been loaded,
  // even where the coordinate lies outside the panel.
  task automatic send_random_item();
    pixel_req_t  r;
    int unsigned w, h, sel;
    logic [4:0]  mbyte;
    r = mload(panel_e'($urandom_range(0, 3)), 5'($urandom), 8'($urandom));
    w = panel_cols(r.panel);
    h = panel_rows(r.panel);
    if ($urandom_range(99) >= 22) begin
      r.kind = REQ_PIXEL;
      r.x = ($urandom_range(99) < 85) ? 5'($urandom_range(0, w - 1)) : 5'($urandom);
      r.y = ($urandom_range(99) < 85) ? 4'($urandom_range(0, h - 1)) : 4'($urandom);
      sel = $urandom_range(99);
      r.mode = (sel < 30) ? WM_UNCOND : (sel < 60) ? WM_MASKED :
               (sel < 92) ? WM_CHECKER : WM_RESERVED;
      case ($urandom_range(0, 9))
        0:       r.gain = '0;
        1:       r.gain = GAIN_FULL;
        2:       r.gain = '1;
        3:       r.gain = GAIN_W'($urandom_range(257, 511));
        default: r.gain = GAIN_W'($urandom_range(0, 256));
      endcase
      if ($urandom_range(0, 9) == 0) r.rgb = $urandom_range(0, 1) ? '1 : '0;
      if (r.mode == WM_MASKED || r.mode == WM_CHECKER) begin
        mbyte = 5'((r.y * w + r.x) >> 3);
        if (!mask_loaded[{r.panel, mbyte}]) send_item(mload(r.panel, mbyte, 8'($urandom)));
      end
    end
    send_item(r);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // A trailing mask load produces no result; its write is done at its input transfer.
    repeat (8) @(posedge clk_i);
  endtask

  // Back-to-back accesses go straight from one access cycle to the next setup cycle.
  task automatic apb_access(input reg_idx_e idx, input logic wr, input logic [OFF_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic apb_idle();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_offsets(input logic [OFF_W-1:0] fl, input logic [OFF_W-1:0] fr,
                             input logic [OFF_W-1:0] sl, input logic [OFF_W-1:0] sr);
    apb_access(REG_OFF_FL, 1'b1, fl);
    apb_access(REG_OFF_FR, 1'b1, fr);
    apb_access(REG_OFF_SL, 1'b1, sl);
    apb_access(REG_OFF_SR, 1'b1, sr);
    apb_access(REG_OFF_FL, 1'b0, '0);
    apb_access(REG_OFF_FR, 1'b0, '0);
    apb_access(REG_OFF_SL, 1'b0, '0);
    apb_access(REG_OFF_SR, 1'b0, '0);
    apb_idle();
  endtask

  initial begin : result_sink
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (calm) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 14);
      end
    end
  end

  initial begin : watchdog
    #3_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_access(REG_OFF_FL, 1'b0, '0);
    apb_access(REG_OFF_SR, 1'b0, '0);
    apb_idle();

    send_item(mload(PANEL_FL, 5'd0, 8'hA5));
    send_item(mload(PANEL_FL, 5'd1, 8'h3C));
    send_item(mload(PANEL_SR, 5'd31, 8'hFF));
    send_item(pix(PANEL_FL, 0, 0, WM_MASKED, 24'hFFFFFF, 256));
    send_item(pix(PANEL_FL, 1, 0, WM_MASKED, 24'h123456, 128));
    send_item(pix(PANEL_FL, 2, 0, WM_CHECKER, 24'hABCDEF, 200));
    send_item(pix(PANEL_FL, 5, 0, WM_CHECKER, 24'hABCDEF, 200));
    send_item(pix(PANEL_FL, 3, 3, WM_RESERVED, 24'hFFFFFF, 256));
    send_item(pix(PANEL_FL, 15, 15, WM_UNCOND, 24'hFFFFFF, 511));
    send_item(pix(PANEL_FL, 16, 0, WM_UNCOND, 24'hFFFFFF, 256));
    // Out of the panel with a bit index past the end of its mask.
    send_item(pix(PANEL_FL, 31, 15, WM_MASKED, 24'hFFFFFF, 256));
    send_item(pix(PANEL_FR, 7, 15, WM_UNCOND, 24'hFFFFFF, 0));
    send_item(pix(PANEL_FR, 8, 0, WM_UNCOND, 24'h00FF00, 256));
    send_item(pix(PANEL_FR, 0, 1, WM_UNCOND, 24'h00FF00, 255));
    send_item(pix(PANEL_SL, 31, 7, WM_UNCOND, 24'h0000FF, 256));
    send_item(pix(PANEL_SL, 0, 0, WM_UNCOND, 24'h0000FF, 1));
    send_item(pix(PANEL_SL, 0, 8, WM_UNCOND, 24'hFFFFFF, 256));
    send_item(pix(PANEL_SR, 31, 7, WM_MASKED, 24'hFFFFFF, 300));
    send_item(pix(PANEL_SR, 0, 0, WM_UNCOND, 24'h010203, 256));
    send_item(pix(PANEL_SR, 31, 0, WM_UNCOND, 24'h808080, 255));

    for (int ph = 0; ph < 5; ph++) begin
      wait_drained();
      case (ph)
        0: set_offsets('0, '0, '0, '0);
        1: set_offsets('1, '1, '1, '1);
        3: set_offsets('1, '0, OFF_W'($urandom), 11'd1792);
        default: set_offsets(OFF_W'($urandom), OFF_W'($urandom), OFF_W'($urandom),
                             OFF_W'($urandom));
      endcase
      for (int n = 0; n < 226; n++) begin
        calm = (ph == 2 && n < 150);
        // The result side stops for a long while as the requests keep coming.
        if (ph == 1 && n == 60) sink_hold_req = 1'b1;
        if (ph == 3 && n == 100) wait_drained();
        send_random_item();
      end
    end
    calm = 1'b0;
    wait_drained();
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// File: masked_serpentine_pixel_mapper.f
+incdir+design
design/msp_pkg.sv
design/msp_ram.sv
design/msp_xy_map.sv
design/msp_color_scale.sv
design/masked_serpentine_pixel_mapper.sv
verif/pixel_result_checker.sv
verif/tb_top.sv
